// ===== hdl/crcgec_pkg.sv =====
package crcgec_pkg;

   localparam int MAX_DEGREE_DEFAULT = 32;
   localparam int QUEUE_DEPTH = 4;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int POLY_W      = 32;
   localparam int DEGREE_W    = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_GEN_POLY   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GEN_DEGREE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHECK_MODE = 2'd2;

   localparam logic [POLY_W-1:0]   GEN_POLY_RESET   = 32'd7;
   localparam logic [DEGREE_W-1:0] GEN_DEGREE_RESET = 6'd3;

   // per-item control handed from the front to the back
   typedef struct packed {
      logic data_bit;
      logic frame_end;
      logic check;
      logic error;
   } crcgec_ctl_type;

   localparam int CTL_W = $bits(crcgec_ctl_type);

endpackage

// ===== hdl/crcgec_queue.sv =====
module crcgec_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             not_empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data  = entry_ff[rd_ptr_ff];
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);

endmodule

// ===== hdl/crcgec_front.sv =====
module crcgec_front #(
   parameter int MAX_DEGREE = crcgec_pkg::MAX_DEGREE_DEFAULT,
   parameter int IDX_W      = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [crcgec_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [crcgec_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              data_bit,
   input  logic                              frame_end,
   input  logic                              q_full,
   output logic                              q_push,
   output crcgec_pkg::crcgec_ctl_type        q_ctl,
   output logic [MAX_DEGREE-1:0]             q_snap,
   output logic [IDX_W-1:0]                  q_dm1
);
   import crcgec_pkg::*;

   localparam int PW = (MAX_DEGREE < POLY_W) ? MAX_DEGREE : POLY_W;

   logic [POLY_W-1:0]     gen_poly_ff;
   logic [DEGREE_W-1:0]   gen_degree_ff;
   logic                  check_mode_ff;
   logic [MAX_DEGREE-1:0] rem_ff, rem_in;

   logic [IDX_W-1:0]      dm1;
   logic [MAX_DEGREE-1:0] mask;
   logic [MAX_DEGREE-1:0] poly;
   logic [MAX_DEGREE-1:0] shifted;
   logic [MAX_DEGREE-1:0] rem_next;
   logic                  top;
   logic                  fb;
   logic                  accept;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_poly_ff   <= GEN_POLY_RESET;
         gen_degree_ff <= GEN_DEGREE_RESET;
         check_mode_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GEN_POLY:   gen_poly_ff   <= csr_wdata;
            CSR_GEN_DEGREE: gen_degree_ff <= csr_wdata[DEGREE_W-1:0];
            CSR_CHECK_MODE: check_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // effective degree minus one, clamped to 1..MAX_DEGREE
   always_comb begin
      if (gen_degree_ff == '0) begin
         dm1 = '0;
      end else if ({1'b0, gen_degree_ff} > (DEGREE_W+1)'(MAX_DEGREE)) begin
         dm1 = IDX_W'(MAX_DEGREE - 1);
      end else begin
         dm1 = IDX_W'(gen_degree_ff - 1'b1);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_DEGREE; i++) begin
         mask[i] = (dm1 >= IDX_W'(i));
      end
   end

   assign poly    = MAX_DEGREE'(gen_poly_ff[PW-1:0]) & mask;
   assign top     = rem_ff[dm1];
   assign fb      = data_bit ^ top;
   assign shifted = rem_ff << 1;

   always_comb begin
      if (check_mode_ff) begin
         rem_next = (shifted | MAX_DEGREE'(data_bit)) & mask;
         if (top) begin
            rem_next = rem_next ^ poly;
         end
      end else begin
         rem_next = shifted & mask;
         if (fb) begin
            rem_next = rem_next ^ poly;
         end
      end
   end

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign rem_in     = frame_end ? '0 : rem_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else if (accept) begin
         rem_ff <= rem_in;
      end
   end

   // mid-frame check bits give no result
   assign q_push          = accept && (!check_mode_ff || frame_end);
   assign q_ctl.data_bit  = data_bit;
   assign q_ctl.frame_end = frame_end;
   assign q_ctl.check     = check_mode_ff;
   assign q_ctl.error     = (rem_next != '0);
   assign q_snap          = rem_next;
   assign q_dm1           = dm1;

endmodule

// ===== hdl/crcgec_back.sv =====
module crcgec_back #(
   parameter int MAX_DEGREE = crcgec_pkg::MAX_DEGREE_DEFAULT,
   parameter int IDX_W      = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_not_empty,
   output logic                       q_pop,
   input  crcgec_pkg::crcgec_ctl_type q_ctl,
   input  logic [MAX_DEGREE-1:0]      q_snap,
   input  logic [IDX_W-1:0]           q_dm1,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic                       out_bit,
   output logic                       is_remainder,
   output logic                       out_last,
   output logic                       error_flag
);
   import crcgec_pkg::*;

   logic                  valid_ff, valid_in;
   logic                  bit_ff, bit_in;
   logic                  rem_flag_ff, rem_flag_in;
   logic                  last_ff, last_in;
   logic                  err_ff, err_in;
   logic                  tail_ff, tail_in;
   logic [MAX_DEGREE-1:0] snap_ff, snap_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   logic                  advance;

   assign advance = !valid_ff || rsp_tready;

   always_comb begin
      valid_in    = valid_ff;
      bit_in      = bit_ff;
      rem_flag_in = rem_flag_ff;
      last_in     = last_ff;
      err_in      = err_ff;
      tail_in     = tail_ff;
      snap_in     = snap_ff;
      cnt_in      = cnt_ff;
      q_pop       = 1'b0;
      if (advance) begin
         if (tail_ff) begin
            // remainder bits, MSB first
            valid_in    = 1'b1;
            bit_in      = snap_ff[cnt_ff];
            rem_flag_in = 1'b1;
            last_in     = (cnt_ff == '0);
            err_in      = 1'b0;
            if (cnt_ff == '0) begin
               tail_in = 1'b0;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end else if (q_not_empty) begin
            q_pop       = 1'b1;
            valid_in    = 1'b1;
            rem_flag_in = 1'b0;
            if (q_ctl.check) begin
               bit_in  = 1'b0;
               last_in = 1'b1;
               err_in  = q_ctl.error;
            end else begin
               bit_in  = q_ctl.data_bit;
               last_in = 1'b0;
               err_in  = 1'b0;
               if (q_ctl.frame_end) begin
                  tail_in = 1'b1;
                  snap_in = q_snap;
                  cnt_in  = q_dm1;
               end
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tail_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tail_ff  <= tail_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff      <= bit_in;
      rem_flag_ff <= rem_flag_in;
      last_ff     <= last_in;
      err_ff      <= err_in;
      snap_ff     <= snap_in;
   end

   assign rsp_tvalid   = valid_ff;
   assign out_bit      = bit_ff;
   assign is_remainder = rem_flag_ff;
   assign out_last     = last_ff;
   assign error_flag   = err_ff;

endmodule

// ===== hdl/crc_generic_encode_check.sv =====
// Channel   Dir  Handshake                Payload
// req       in   req_tvalid/req_tready    tdata[0] data_bit, tlast frame_end
// rsp       out  rsp_tvalid/rsp_tready    tdata[0] out_bit, tdata[1] error_flag,
//                                          tuser is_remainder, tlast out_last
// csr       in   csr_valid/csr_ready      csr_index, csr_wdata
//
// One bit per cycle in and out while the queue has room and rsp_tready is high; the
// running remainder updates in the cycle a bit is accepted and the result leaves
// through a registered output stage. An encode frame end adds d remainder bits
// on the output, during which a 4-entry queue keeps taking input bits before
// req_tready drops. Synchronous active-high reset clears the remainder and loads
// generator 7, degree 3, encode mode. csr_ready is held high, so csr writes never stall.
module crc_generic_encode_check #(
   parameter int MAX_DEGREE = crcgec_pkg::MAX_DEGREE_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // [0] data_bit
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata,  // [0] out_bit, [1] error_flag
   output logic                               rsp_tuser,  // [0] is_remainder
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [crcgec_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [crcgec_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import crcgec_pkg::*;

   localparam int IDX_W   = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
   localparam int ENTRY_W = MAX_DEGREE + IDX_W + CTL_W;

   logic                  q_push, q_pop, q_full, q_not_empty;
   crcgec_ctl_type        push_ctl, pop_ctl;
   logic [MAX_DEGREE-1:0] push_snap, pop_snap;
   logic [IDX_W-1:0]      push_dm1, pop_dm1;
   logic [ENTRY_W-1:0]    push_data, pop_data;
   logic                  out_bit, error_flag;

   crcgec_front #(
      .MAX_DEGREE (MAX_DEGREE),
      .IDX_W      (IDX_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .data_bit   (req_tdata[0]),
      .frame_end  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_ctl      (push_ctl),
      .q_snap     (push_snap),
      .q_dm1      (push_dm1)
   );

   assign push_data = {push_snap, push_dm1, push_ctl};

   crcgec_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   assign pop_ctl  = crcgec_ctl_type'(pop_data[CTL_W-1:0]);
   assign pop_dm1  = pop_data[CTL_W +: IDX_W];
   assign pop_snap = pop_data[CTL_W+IDX_W +: MAX_DEGREE];

   crcgec_back #(
      .MAX_DEGREE (MAX_DEGREE),
      .IDX_W      (IDX_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_not_empty  (q_not_empty),
      .q_pop        (q_pop),
      .q_ctl        (pop_ctl),
      .q_snap       (pop_snap),
      .q_dm1        (pop_dm1),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .out_bit      (out_bit),
      .is_remainder (rsp_tuser),
      .out_last     (rsp_tlast),
      .error_flag   (error_flag)
   );

   assign rsp_tdata = {6'b0, error_flag, out_bit};

   // an error can only be reported on the single check-mode result
   a_err_is_check_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && error_flag |-> rsp_tlast && !rsp_tuser && !out_bit)
      else $error("error flag on a result that is not a check result");

   // remainder bits leave back to back until the last one
   a_remainder_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser && !rsp_tlast |=> rsp_tvalid && rsp_tuser)
      else $error("remainder run broken before its last bit");

   // no queue read while the output is stalled
   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty && (!rsp_tvalid || rsp_tready))
      else $error("queue read without data or output room");

endmodule

// ===== tb/sv/tb_crc_generic_encode_check.sv =====
module tb_crc_generic_encode_check;
   import crcgec_pkg::*;

   localparam int TOP_DEGREE  = MAX_DEGREE_DEFAULT;
   localparam int SETTLE_GAP  = 48;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic data_bit;
      logic frame_end;
   } frame_bit_type;

   typedef struct packed {
      logic out_bit;
      logic is_remainder;
      logic out_last;
      logic error_flag;
   } crc_result_type;

   typedef enum {FRAME_PLAIN, FRAME_CODEWORD, FRAME_CORRUPT, FRAME_OPEN} frame_kind_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = 8'd0;  // [0] data_bit
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;         // [0] out_bit, [1] error_flag
   logic                   rsp_tuser;         // [0] is_remainder
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // predictor copy of the registers and the running remainder
   logic [POLY_W-1:0]   cfg_poly   = GEN_POLY_RESET;
   logic [DEGREE_W-1:0] cfg_degree = GEN_DEGREE_RESET;
   logic                cfg_check  = 1'b0;
   logic [63:0]         crc_rem    = 64'd0;

   frame_bit_type  bits_to_send[$];
   crc_result_type results_due[$];
   bit             req_sent = 1'b0;
   bit             no_gaps = 1'b0;
   int             items_queued = 0;
   int             result_count = 0;
   int             mismatch_count = 0;
   int             cycle_count = 0;

   crc_generic_encode_check dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic bit take_break();
      return !no_gaps && ($urandom_range(0, 99) < 27);
   endfunction

   function automatic int eff_degree();
      if (cfg_degree < 1) return 1;
      if (cfg_degree > TOP_DEGREE) return TOP_DEGREE;
      return int'(cfg_degree);
   endfunction

   // one division step; augmented form feeds the bit into the feedback (encode),
   // the direct form shifts it into the register (check)
   function automatic logic [63:0] crc_shift(input logic [63:0] r, input logic b,
                                             input logic augmented);
      int          d;
      logic [63:0] mask;
      logic [63:0] poly;
      logic [63:0] nxt;
      logic        top;
      d    = eff_degree();
      mask = (64'd1 << d) - 64'd1;
      poly = {32'd0, cfg_poly} & mask;
      top  = r[d-1];
      if (augmented) begin
         nxt = (r << 1) & mask;
         if (b ^ top) nxt = nxt ^ poly;
      end else begin
         nxt = ((r << 1) | {63'd0, b}) & mask;
         if (top) nxt = nxt ^ poly;
      end
      return nxt;
   endfunction

   task automatic divide_bit(input logic b, input logic e);
      int d;
      int i;
      d = eff_degree();
      if (cfg_check) begin
         crc_rem = crc_shift(crc_rem, b, 1'b0);
         if (e) begin
            results_due.push_back({1'b0, 1'b0, 1'b1, crc_rem != 64'd0});
            crc_rem = 64'd0;
         end
      end else begin
         crc_rem = crc_shift(crc_rem, b, 1'b1);
         results_due.push_back({b, 1'b0, 1'b0, 1'b0});
         if (e) begin
            for (i = d; i > 0; i--)
               results_due.push_back({crc_rem[i-1], 1'b1, i == 1, 1'b0});
            crc_rem = 64'd0;
         end
      end
   endtask

   task automatic note_mismatch(input string what, input int got, input int want);
      $display("mismatch on result %0d, %s: got %0d, want %0d", result_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_GEN_POLY:   cfg_poly = val;
         CSR_GEN_DEGREE: cfg_degree = val[DEGREE_W-1:0];
         CSR_CHECK_MODE: cfg_check = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // message bits; a codeword gets its remainder appended under the current generator
   task automatic queue_frame(input int len, input frame_kind_type kind);
      frame_bit_type frm[0:71];
      logic [63:0]   r;
      int            n;
      int            i;
      r = 64'd0;
      n = 0;
      for (i = 0; i < len; i++) begin
         frm[n].data_bit  = 1'($urandom_range(0, 1));
         frm[n].frame_end = 1'b0;
         r = crc_shift(r, frm[n].data_bit, 1'b1);
         n++;
      end
      if (kind == FRAME_CODEWORD || kind == FRAME_CORRUPT) begin
         for (i = eff_degree(); i > 0; i--) begin
            frm[n].data_bit  = r[i-1];
            frm[n].frame_end = 1'b0;
            n++;
         end
      end
      if (kind == FRAME_CORRUPT) begin
         i = $urandom_range(0, n - 1);
         frm[i].data_bit = ~frm[i].data_bit;
      end
      if (kind != FRAME_OPEN) frm[n-1].frame_end = 1'b1;
      for (i = 0; i < n; i++) bits_to_send.push_back(frm[i]);
      items_queued += n;
   endtask

   task automatic settle();
      do @(posedge clock);
      while (bits_to_send.size() != 0 || req_tvalid || results_due.size() != 0);
      repeat (SETTLE_GAP) @(posedge clock);
   endtask

   // driver: a presented transaction holds until it is taken
   always @(negedge clock) begin : driver
      frame_bit_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_sent) begin
         if (bits_to_send.size() != 0 && !take_break()) begin
            nxt = bits_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {7'd0, nxt.data_bit};
            req_tlast  <= nxt.frame_end;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      req_sent = 1'b0;
      rsp_tready <= !take_break();
   end

   always @(posedge clock) begin : monitor
      crc_result_type want;
      if (!reset && req_tvalid && req_tready) begin
         divide_bit(req_tdata[0], req_tlast);
         req_sent = 1'b1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (results_due.size() == 0) begin
            note_mismatch("unexpected result", 1, 0);
         end else begin
            want = results_due.pop_front();
            if (rsp_tdata[0] !== want.out_bit)
               note_mismatch("out_bit", rsp_tdata[0], want.out_bit);
            if (rsp_tuser !== want.is_remainder)
               note_mismatch("is_remainder", rsp_tuser, want.is_remainder);
            if (rsp_tlast !== want.out_last)
               note_mismatch("out_last", rsp_tlast, want.out_last);
            if (rsp_tdata[1] !== want.error_flag)
               note_mismatch("error_flag", rsp_tdata[1], want.error_flag);
         end
         result_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** crc_generic_encode_check: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      int             ph;
      int             len;
      int             pick;
      int             start;
      logic [5:0]     deg;
      logic [31:0]    poly;
      frame_kind_type kind;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset generator: x^3 + x^2 + x + 1, encode
      queue_frame(1, FRAME_PLAIN);
      queue_frame(4, FRAME_PLAIN);
      settle();
      // degree 0 behaves as 1; generator bits above the degree are dropped
      write_reg(CSR_GEN_DEGREE, 32'd0);
      write_reg(CSR_GEN_POLY, 32'hFFFF_FFFE);
      queue_frame(2, FRAME_PLAIN);
      settle();
      // degree past the maximum clamps, full-width remainder
      write_reg(CSR_GEN_DEGREE, 32'd63);
      write_reg(CSR_GEN_POLY, 32'hFFFF_FFFF);
      queue_frame(3, FRAME_PLAIN);
      settle();
      write_reg(CSR_GEN_DEGREE, 32'd32);
      write_reg(CSR_GEN_POLY, 32'd0);
      queue_frame(1, FRAME_PLAIN);
      settle();
      // check mode: clean codeword, then one with a flipped bit
      write_reg(CSR_GEN_DEGREE, 32'd3);
      write_reg(CSR_GEN_POLY, 32'd3);
      write_reg(CSR_CHECK_MODE, 32'd1);
      queue_frame(2, FRAME_CODEWORD);
      queue_frame(2, FRAME_CORRUPT);
      settle();

      for (ph = 0; ph < 10; ph++) begin
         case ($urandom_range(0, 5))
            0: deg = 6'd1;
            1: deg = 6'd32;
            2: deg = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
            default: deg = 6'($urandom_range(2, 31));
         endcase
         case ($urandom_range(0, 5))
            0: poly = 32'd0;
            1: poly = 32'hFFFF_FFFF;
            default: poly = $urandom();
         endcase
         write_reg(CSR_GEN_POLY, poly);
         write_reg(CSR_GEN_DEGREE, {26'd0, deg});
         write_reg(CSR_CHECK_MODE, (ph < 8) ? 32'(ph % 2) : 32'($urandom_range(0, 1)));
         no_gaps = (ph == 4);
         start = items_queued;
         while (items_queued - start < 36) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            pick = $urandom_range(0, 19);
            if (!cfg_check || pick < 3) kind = FRAME_PLAIN;
            else if (pick < 6) kind = FRAME_CORRUPT;
            else kind = FRAME_CODEWORD;
            queue_frame(len, kind);
         end
         // leave a frame open so the next register change lands mid frame
         if (ph % 3 == 2) queue_frame($urandom_range(1, 6), FRAME_OPEN);
         settle();
      end
      no_gaps = 1'b0;

      if (mismatch_count == 0) begin
         $display("** crc_generic_encode_check: PASSED **");
      end else begin
         $display("** crc_generic_encode_check: FAILED **");
      end
      $finish;
   end

endmodule
